// ===== sv/mfm_pkg.sv =====
// ----------------------------------------------------------------------------
// mfm_pkg
// Shared types and constants for the Q(sqrt3, sqrt5, sqrt11) multiplier.
// ----------------------------------------------------------------------------
package mfm_pkg;

    localparam int COEF_WIDTH = 64;              // signed coefficient width, 16..64
    localparam int FIELD_W    = 64;              // port field width of a coefficient
    localparam int BASIS_SIZE = 8;
    localparam int IDX_W      = $clog2(BASIS_SIZE);
    localparam int HALF_W     = (COEF_WIDTH + 1) / 2;
    localparam int PROD_W     = 2 * COEF_WIDTH;
    localparam int SCALE_W    = PROD_W + 8;      // 3*5*11 = 165 < 2^8
    localparam int ACC_W      = SCALE_W + 4;     // sign plus eight terms

    typedef enum logic [1:0] {
        SCALE_3,
        SCALE_5,
        SCALE_11
    } scale_t;

    typedef struct packed {
        logic [2:0]                coef_index;
        logic signed [FIELD_W-1:0] left_coef;
        logic signed [FIELD_W-1:0] right_coef;
        logic                      load_done;
    } load_item_t;

    typedef struct packed {
        logic [2:0]                result_index;
        logic signed [FIELD_W-1:0] result_coef;
        logic                      overflow;
        logic                      last_result;
    } result_item_t;

    typedef struct packed {
        logic [IDX_W-1:0] left_addr;
        logic [IDX_W-1:0] right_addr;
        logic             acc_clear;
        logic             opnd_load;
        logic             mul_en;
        logic [1:0]       mul_sel;    // bit0: left half, bit1: right half
        logic             prod_add;
        logic             scale_en;
        scale_t           scale_sel;
        logic             term_add;
        logic             emit;
        logic [IDX_W-1:0] res_index;
        logic             res_last;
    } dp_cmd_t;

endpackage

// ===== sv/mfm_ram.sv =====
// ----------------------------------------------------------------------------
// mfm_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module mfm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/mfm_ctrl.sv =====
// ----------------------------------------------------------------------------
// mfm_ctrl
// Sequencer: walks k over the result basis and i over the terms of each k.
// ----------------------------------------------------------------------------
module mfm_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            launch,
    output logic            busy,
    output mfm_pkg::dp_cmd_t cmd
);
    import mfm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_OPND,
        S_MUL,
        S_MFIN,
        S_SCALE,
        S_ACCUM,
        S_EMIT
    } state_t;

    state_t           state_reg;
    logic [IDX_W-1:0] k_reg;
    logic [IDX_W-1:0] i_reg;
    logic [1:0]       q_reg;
    logic [1:0]       b_reg;

    logic [IDX_W-1:0] j_idx;
    logic [IDX_W-1:0] common;

    assign j_idx  = i_reg ^ k_reg;
    assign common = i_reg & j_idx;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            k_reg     <= '0;
            i_reg     <= '0;
            q_reg     <= '0;
            b_reg     <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    k_reg <= '0;
                    i_reg <= '0;
                    if (launch)
                    begin
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    state_reg <= S_OPND;
                end
                S_OPND:
                begin
                    q_reg     <= '0;
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    q_reg <= q_reg + 2'd1;
                    if (q_reg == 2'd3)
                    begin
                        state_reg <= S_MFIN;
                    end
                end
                S_MFIN:
                begin
                    b_reg     <= '0;
                    state_reg <= S_SCALE;
                end
                S_SCALE:
                begin
                    b_reg <= b_reg + 2'd1;
                    if (b_reg == 2'd2)
                    begin
                        state_reg <= S_ACCUM;
                    end
                end
                S_ACCUM:
                begin
                    i_reg <= i_reg + 1'b1;
                    if (i_reg == IDX_W'(BASIS_SIZE - 1))
                    begin
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        state_reg <= S_READ;
                    end
                end
                S_EMIT:
                begin
                    k_reg <= k_reg + 1'b1;
                    if (k_reg == IDX_W'(BASIS_SIZE - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_READ;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        cmd            = '0;
        cmd.left_addr  = i_reg;
        cmd.right_addr = j_idx;
        cmd.res_index  = k_reg;
        cmd.res_last   = (k_reg == IDX_W'(BASIS_SIZE - 1));
        cmd.mul_sel    = q_reg;
        case (b_reg)
            2'd1:    cmd.scale_sel = SCALE_5;
            2'd2:    cmd.scale_sel = SCALE_11;
            default: cmd.scale_sel = SCALE_3;
        endcase
        case (state_reg)
            S_IDLE:  cmd.acc_clear = 1'b1;
            S_OPND:  cmd.opnd_load = 1'b1;
            S_MUL:
            begin
                cmd.mul_en   = 1'b1;
                cmd.prod_add = (q_reg != 2'd0);   // previous partial product
            end
            S_MFIN:  cmd.prod_add = 1'b1;
            S_SCALE: cmd.scale_en = common[b_reg];
            S_ACCUM: cmd.term_add = 1'b1;
            S_EMIT:
            begin
                cmd.emit      = 1'b1;
                cmd.acc_clear = 1'b1;
            end
            default: cmd.acc_clear = 1'b0;
        endcase
    end

endmodule

// ===== sv/mfm_datapath.sv =====
// ----------------------------------------------------------------------------
// mfm_datapath
// Operand stores, split multiplier, scaler, accumulator and result register.
// ----------------------------------------------------------------------------
module mfm_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  mfm_pkg::load_item_t  load,
    input  mfm_pkg::dp_cmd_t     cmd,
    output logic                 result_strobe,
    output mfm_pkg::result_item_t result
);
    import mfm_pkg::*;

    logic [COEF_WIDTH-1:0] left_rd;
    logic [COEF_WIDTH-1:0] right_rd;

    mfm_ram #(
        .WIDTH (COEF_WIDTH),
        .DEPTH (BASIS_SIZE)
    ) u_left_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (load.coef_index),
        .wdata (load.left_coef[COEF_WIDTH-1:0]),
        .raddr (cmd.left_addr),
        .rdata (left_rd)
    );

    mfm_ram #(
        .WIDTH (COEF_WIDTH),
        .DEPTH (BASIS_SIZE)
    ) u_right_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (load.coef_index),
        .wdata (load.right_coef[COEF_WIDTH-1:0]),
        .raddr (cmd.right_addr),
        .rdata (right_rd)
    );

    // magnitudes and sign of the current term
    logic [COEF_WIDTH-1:0] a_mag_reg, b_mag_reg;
    logic                  neg_reg;
    logic [COEF_WIDTH-1:0] a_mag_next, b_mag_next;

    assign a_mag_next = left_rd[COEF_WIDTH-1]  ? (COEF_WIDTH'(0) - left_rd)  : left_rd;
    assign b_mag_next = right_rd[COEF_WIDTH-1] ? (COEF_WIDTH'(0) - right_rd) : right_rd;

    // half-word partial products
    logic [HALF_W-1:0]   a_half, b_half;
    logic [2*HALF_W-1:0] pp_reg;
    logic [1:0]          pp_sel_reg;

    assign a_half = cmd.mul_sel[0] ? HALF_W'(a_mag_reg[COEF_WIDTH-1:HALF_W])
                                   : a_mag_reg[HALF_W-1:0];
    assign b_half = cmd.mul_sel[1] ? HALF_W'(b_mag_reg[COEF_WIDTH-1:HALF_W])
                                   : b_mag_reg[HALF_W-1:0];

    logic [SCALE_W-1:0] prod_reg;
    logic [SCALE_W-1:0] pp_shifted;
    logic [SCALE_W-1:0] scaled;

    always_comb
    begin
        case (pp_sel_reg)
            2'd0:    pp_shifted = SCALE_W'(pp_reg);
            2'd3:    pp_shifted = SCALE_W'(pp_reg) << (2 * HALF_W);
            default: pp_shifted = SCALE_W'(pp_reg) << HALF_W;
        endcase
    end

    always_comb
    begin
        case (cmd.scale_sel)
            SCALE_3:  scaled = prod_reg + (prod_reg << 1);
            SCALE_5:  scaled = prod_reg + (prod_reg << 2);
            SCALE_11: scaled = prod_reg + (prod_reg << 1) + (prod_reg << 3);
            default:  scaled = prod_reg;
        endcase
    end

    // signed accumulation: add or subtract through carry-in
    logic [ACC_W-1:0] acc_reg;
    logic [ACC_W-1:0] term_ext;
    logic [ACC_W-1:0] term_xor;

    assign term_ext = ACC_W'(prod_reg);
    assign term_xor = term_ext ^ {ACC_W{neg_reg}};

    always_ff @(posedge clk)
    begin
        if (cmd.opnd_load)
        begin
            a_mag_reg <= a_mag_next;
            b_mag_reg <= b_mag_next;
            neg_reg   <= left_rd[COEF_WIDTH-1] ^ right_rd[COEF_WIDTH-1];
        end
        if (cmd.mul_en)
        begin
            pp_reg     <= a_half * b_half;
            pp_sel_reg <= cmd.mul_sel;
        end
        if (cmd.opnd_load)
        begin
            prod_reg <= '0;
        end
        else if (cmd.prod_add)
        begin
            prod_reg <= prod_reg + pp_shifted;
        end
        else if (cmd.scale_en)
        begin
            prod_reg <= scaled;
        end
        if (cmd.acc_clear)
        begin
            acc_reg <= '0;
        end
        else if (cmd.term_add)
        begin
            acc_reg <= acc_reg + term_xor + ACC_W'(neg_reg);
        end
    end

    // result register
    logic signed [COEF_WIDTH-1:0] low_word;
    logic [ACC_W-COEF_WIDTH:0]    upper;
    result_item_t                 result_reg;
    logic                         strobe_reg;

    assign low_word = acc_reg[COEF_WIDTH-1:0];
    assign upper    = acc_reg[ACC_W-1:COEF_WIDTH-1];

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            result_reg.result_index <= cmd.res_index;
            result_reg.result_coef  <= FIELD_W'(low_word);
            result_reg.overflow     <= !((&upper) || !(|upper));
            result_reg.last_result  <= cmd.res_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= cmd.emit;
        end
    end

    assign result_strobe = strobe_reg;
    assign result        = result_reg;

endmodule

// ===== sv/multiquadratic_field_multiply.sv =====
// ----------------------------------------------------------------------------
// multiquadratic_field_multiply
// Product of two elements of Q(sqrt3, sqrt5, sqrt11), eight coefficients each.
// ----------------------------------------------------------------------------
// Usage: each load item (start high while busy is low) writes one coefficient
// of both operands at coef_index, one item per cycle. An item with load_done
// set also starts the product; busy then stays high until the last result has
// been produced. Results come out in index order 0..7, each on result for one
// cycle with result_strobe high; the receiver cannot stall, so it must take
// every strobe. last_result marks index 7, overflow marks a coefficient whose
// exact value does not fit the signed coefficient width (result_coef then
// holds its low bits). The strobe of the final result lands in the first
// cycle with busy low, so the next load can already be taken then.
//
// Sequence: the product is a walk over k = 0..7, each summing eight terms
// left[i] * right[i ^ k]. Each term takes a store read, an operand latch,
// four half-word 32x32 partial products through the single multiplier
// plus a drain step, three scale steps for sqrt3, sqrt5 and sqrt11, and
// the signed accumulate. Each k ends in an emit step. A load_done item
// keeps the block busy through the whole walk; plain items leave it idle.
//
// Operand entries never written are read as whatever the store holds.
// ----------------------------------------------------------------------------
module multiquadratic_field_multiply (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  mfm_pkg::load_item_t   load,
    output logic                  result_strobe,
    output mfm_pkg::result_item_t result
);
    import mfm_pkg::*;

    logic    accept;      // load item taken this cycle
    logic    launch;      // item also starts the product
    dp_cmd_t cmd;

    assign accept = start && !busy;
    assign launch = accept && load.load_done;

    mfm_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .launch (launch),
        .busy   (busy),
        .cmd    (cmd)
    );

    mfm_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .wr_en         (accept),
        .load          (load),
        .cmd           (cmd),
        .result_strobe (result_strobe),
        .result        (result)
    );

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Q(sqrt3, sqrt5, sqrt11) field multiplier.
// ----------------------------------------------------------------------------
// Load items are driven on the command port with random gaps between them.
// Every accepted item updates a local copy of both operand stores. A load_done
// item triggers an exact product in wide signed arithmetic, which yields eight
// expected coefficients. A checker compares each strobed result with the
// oldest pending coefficient. A watchdog ends the run when nothing moves for
// too long.
// ----------------------------------------------------------------------------
module testbench;
    import mfm_pkg::*;

    localparam int HALF_PERIOD  = 2;
    localparam int RESET_CYCLES = 9;
    localparam int MAX_GAP      = 12;
    localparam int ITEM_TARGET  = 310;
    // Progress during a product shows as one strobe per result index, and the
    // sender's idle gaps are at most MAX_GAP. STALL_LIMIT quiet cycles is far
    // beyond any correct stretch.
    localparam int STALL_LIMIT  = 2000;
    localparam int QUIET_CYCLES = 200;

    // The exact sum needs about 140 bits (128-bit product, x165, 8 terms).
    localparam int WIDE_W = 192;

    // Squares of the basis roots, applied once for each bit shared by i and j.
    localparam int SCALE_SQRT3  = 3;
    localparam int SCALE_SQRT5  = 5;
    localparam int SCALE_SQRT11 = 11;

    // Signed coefficient extremes at COEF_WIDTH, sign-extended to the port width.
    localparam logic [FIELD_W-1:0] COEF_MAX = (FIELD_W'(1) << (COEF_WIDTH - 1)) - 1;
    localparam logic [FIELD_W-1:0] COEF_MIN = ~COEF_MAX;
    localparam logic [FIELD_W-1:0] ALL_ONES = {FIELD_W{1'b1}};

    logic         clk = 1'b0;
    logic         rst_n;
    logic         start;
    logic         busy;
    load_item_t   load;
    logic         result_strobe;
    result_item_t result;

    multiquadratic_field_multiply i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .load          (load),
        .result_strobe (result_strobe),
        .result        (result)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // Local copy of the operand stores. Tests write all eight entries before
    // the first load_done item, so no unwritten entry is ever multiplied.
    logic [FIELD_W-1:0] left_operand  [BASIS_SIZE];
    logic [FIELD_W-1:0] right_operand [BASIS_SIZE];

    result_item_t pending_coefs [$];   // expected coefficients, oldest first
    result_item_t want_coef;

    int mismatch_count = 0;
    int items_sent     = 0;
    int idle_cycles    = 0;
    int burst_left     = 0;            // items left in a run with no gaps

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Take the low COEF_WIDTH bits as two's complement and extend them to the
    // accumulator width. Bits above COEF_WIDTH are ignored.
    function automatic logic signed [WIDE_W-1:0] widen_coef(input logic [FIELD_W-1:0] raw);
        logic signed [COEF_WIDTH-1:0] narrow;
        logic signed [WIDE_W-1:0]     wide;
        narrow = raw[COEF_WIDTH-1:0];
        wide   = narrow;
        return wide;
    endfunction

    // Exact product of the two stored elements. The eight coefficients are
    // queued in index order.
    task automatic multiply_stored_operands();
        logic signed [WIDE_W-1:0]     acc [BASIS_SIZE];
        logic signed [WIDE_W-1:0]     term;
        logic signed [COEF_WIDTH-1:0] low;
        logic signed [FIELD_W-1:0]    low_ext;
        logic [IDX_W-1:0]             shared;
        result_item_t                 coef;
        for (int k = 0; k < BASIS_SIZE; k++)
        begin
            acc[k] = '0;
        end
        for (int i = 0; i < BASIS_SIZE; i++)
        begin
            for (int j = 0; j < BASIS_SIZE; j++)
            begin
                term   = widen_coef(left_operand[i]) * widen_coef(right_operand[j]);
                shared = IDX_W'(i & j);
                if (shared[0])
                    term = term * SCALE_SQRT3;
                if (shared[1])
                    term = term * SCALE_SQRT5;
                if (shared[2])
                    term = term * SCALE_SQRT11;
                acc[i ^ j] = acc[i ^ j] + term;
            end
        end
        for (int k = 0; k < BASIS_SIZE; k++)
        begin
            low                = acc[k][COEF_WIDTH-1:0];
            low_ext            = low;
            coef.result_index  = 3'(k);
            coef.result_coef   = low_ext;
            // overflow: the low bits, sign-extended, do not give back the exact sum
            coef.overflow      = (widen_coef(low_ext) != acc[k]);
            coef.last_result   = (k == BASIS_SIZE - 1);
            pending_coefs.insert(pending_coefs.size(), coef);
        end
    endtask

    task automatic store_and_predict(input load_item_t item);
        left_operand[item.coef_index]  = item.left_coef;
        right_operand[item.coef_index] = item.right_coef;
        if (item.load_done)
            multiply_stored_operands();
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("%0t ns mismatch: %s", $time, what);
    endtask

    // The receiver cannot stall: every strobe is one result.
    always @(posedge clk)
    begin
        if (rst_n && result_strobe)
        begin
            if (pending_coefs.size() == 0)
            begin
                report_mismatch($sformatf("result index %0d with nothing pending",
                                          result.result_index));
            end
            else
            begin
                want_coef = pending_coefs.pop_front();
                if (result.result_index !== want_coef.result_index)
                    report_mismatch($sformatf("result_index %0d, want %0d",
                                              result.result_index, want_coef.result_index));
                if (result.result_coef !== want_coef.result_coef)
                    report_mismatch($sformatf("index %0d result_coef %h, want %h",
                                              want_coef.result_index, result.result_coef,
                                              want_coef.result_coef));
                if (result.overflow !== want_coef.overflow)
                    report_mismatch($sformatf("index %0d overflow %b, want %b",
                                              want_coef.result_index, result.overflow,
                                              want_coef.overflow));
                if (result.last_result !== want_coef.last_result)
                    report_mismatch($sformatf("index %0d last_result %b, want %b",
                                              want_coef.result_index, result.last_result,
                                              want_coef.last_result));
            end
        end
    end

    // Watchdog: counts cycles with neither an accepted item nor a result.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_strobe)
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t ns watchdog: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Idle cycles before the next item: mostly a random number up to MAX_GAP, sometimes a burst of
    // back-to-back items.
    function automatic int draw_gap();
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 9) < 2)
        begin
            burst_left = $urandom_range(4, 20);
            return 0;
        end
        return $urandom_range(0, MAX_GAP);
    endfunction

    function automatic load_item_t make_item(input int idx, input logic [FIELD_W-1:0] left_val,
                                             input logic [FIELD_W-1:0] right_val,
                                             input logic done);
        load_item_t item;
        item.coef_index = 3'(idx);
        item.left_coef  = left_val;
        item.right_coef = right_val;
        item.load_done  = done;
        return item;
    endfunction

    // Mix of magnitudes. Full-width values almost always overflow. Values of
    // about 2^27 stay in range. Values near 2^32 exercise the half-word
    // partial products.
    function automatic logic [FIELD_W-1:0] random_coef();
        logic signed [31:0] s;
        logic [31:0]        r;
        logic [FIELD_W-1:0] v;
        r = $urandom;
        case ($urandom_range(0, 9))
            0, 1, 2:
            begin
                v = {$urandom, $urandom};
            end
            3, 4:
            begin
                s = int'($urandom_range(0, 65535)) - 32768;
                v = {{(FIELD_W - 32){s[31]}}, s};
            end
            5, 6:
            begin
                s = int'($urandom_range(0, (1 << 28) - 1)) - (1 << 27);
                v = {{(FIELD_W - 32){s[31]}}, s};
            end
            7:
            begin
                case ($urandom_range(0, 2))
                    0:       v = {{(FIELD_W - 32){1'b0}}, r};
                    1:       v = {{(FIELD_W - 32){r[31]}}, r};
                    default: v = {r, 32'h0} >> (64 - FIELD_W);
                endcase
            end
            default:
            begin
                case ($urandom_range(0, 5))
                    0:       v = COEF_MAX;
                    1:       v = COEF_MIN;
                    2:       v = '0;
                    3:       v = ALL_ONES;
                    4:       v = FIELD_W'(1);
                    default: v = COEF_MIN + FIELD_W'(1);
                endcase
            end
        endcase
        return v;
    endfunction

    // Drive one item and hold it until taken (start high, busy low at the edge).
    // start stays high on return. In the same time step the next call drives its
    // own item or lowers start, as a pause does, so nothing is taken twice.
    task automatic send_item(input load_item_t item);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        load  <= item;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        store_and_predict(item);
        items_sent++;
    endtask

    // Stop sending until every pending coefficient has come out.
    task automatic wait_results_drained();
        start <= 1'b0;
        @(posedge clk);
        while (pending_coefs.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Zero everywhere except sqrt3*sqrt5*sqrt11 on both sides: squaring it
    // gives 3*5*11 at index 0. This also fills every store entry.
    task automatic test_basis_scaling();
        for (int k = 0; k < BASIS_SIZE - 1; k++)
            send_item(make_item(k, '0, '0, 1'b0));
        send_item(make_item(BASIS_SIZE - 1, FIELD_W'(1), FIELD_W'(1), 1'b1));
    endtask

    // One times an element gives the element back, extremes included.
    task automatic test_identity_element();
        logic [FIELD_W-1:0] pattern [BASIS_SIZE];
        pattern = '{COEF_MAX, COEF_MIN, FIELD_W'(0), ALL_ONES, FIELD_W'(1),
                    {(FIELD_W / 2){2'b01}}, {(FIELD_W / 2){2'b10}},
                    {{(FIELD_W / 2){1'b0}}, {(FIELD_W / 2){1'b1}}}};
        for (int k = 0; k < BASIS_SIZE; k++)
            send_item(make_item(k, (k == 0) ? FIELD_W'(1) : FIELD_W'(0), pattern[k],
                                k == BASIS_SIZE - 1));
    endtask

    // Plain loads only store their coefficients. The next done item then
    // multiplies everything loaded so far.
    task automatic test_load_without_done();
        send_item(make_item(1, FIELD_W'(3), FIELD_W'(-7), 1'b0));
        send_item(make_item(6, FIELD_W'(-5), FIELD_W'(2), 1'b0));
        send_item(make_item(4, FIELD_W'(9), FIELD_W'(9), 1'b1));
    endtask

    // Extreme coefficients push sums far outside the range. The low bits
    // must still come out, with overflow set.
    task automatic test_overflow_extremes();
        send_item(make_item(7, COEF_MIN, COEF_MIN, 1'b1));
        send_item(make_item(0, COEF_MAX, COEF_MAX, 1'b1));
        send_item(make_item(5, COEF_MIN, COEF_MAX, 1'b1));
        send_item(make_item(2, ALL_ONES, COEF_MIN, 1'b1));
    endtask

    // The sender goes quiet until the whole product is out, then starts again
    // from an idle block.
    task automatic test_pause_until_drained();
        send_item(make_item(3, random_coef(), random_coef(), 1'b1));
        wait_results_drained();
        send_item(make_item(3, random_coef(), random_coef(), 1'b1));
    endtask

    // Mostly full operand loads in shuffled order, ending in a done item.
    // The rest are partial updates, plain loads and repeated products.
    task automatic test_random_products();
        int order [BASIS_SIZE];
        int kind;
        int count;
        int pick;
        int swap;
        while (items_sent < ITEM_TARGET)
        begin
            if ($urandom_range(0, 11) == 0)
                wait_results_drained();
            kind = $urandom_range(0, 9);
            if (kind < 6)
            begin
                for (int k = 0; k < BASIS_SIZE; k++)
                    order[k] = k;
                for (int k = BASIS_SIZE - 1; k > 0; k--)
                begin
                    pick        = $urandom_range(0, k);
                    swap        = order[k];
                    order[k]    = order[pick];
                    order[pick] = swap;
                end
                for (int k = 0; k < BASIS_SIZE; k++)
                    send_item(make_item(order[k], random_coef(), random_coef(),
                                        k == BASIS_SIZE - 1));
            end
            else if (kind < 8)
            begin
                count = $urandom_range(1, 4);
                for (int n = 0; n < count; n++)
                    send_item(make_item($urandom_range(0, BASIS_SIZE - 1), random_coef(),
                                        random_coef(), n == count - 1));
            end
            else if (kind < 9)
            begin
                count = $urandom_range(1, 3);
                for (int n = 0; n < count; n++)
                    send_item(make_item($urandom_range(0, BASIS_SIZE - 1), random_coef(),
                                        random_coef(), 1'b0));
            end
            else
            begin
                send_item(make_item($urandom_range(0, BASIS_SIZE - 1), random_coef(),
                                    random_coef(), 1'b1));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n <= 1'b0;
        start <= 1'b0;
        load  <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basis_scaling();
        test_identity_element();
        test_load_without_done();
        test_overflow_extremes();
        test_pause_until_drained();
        test_random_products();

        // All items are in. Wait for the last product, then watch for strays.
        wait_results_drained();
        repeat (QUIET_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== multiquadratic_field_multiply.f =====
sv/mfm_pkg.sv
sv/mfm_ram.sv
sv/mfm_ctrl.sv
sv/mfm_datapath.sv
sv/multiquadratic_field_multiply.sv
bench/testbench.sv
